/* rtl/qnit_pkg.sv */
// Shared constants, types and helpers for the quadtree node interning table.
package qnit_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = 13;
  localparam int MAXE_W     = 12;
  localparam int LVL_W      = 6;
  localparam int ID_W       = 64;

  localparam logic [ID_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [ID_W-1:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
  localparam logic [ID_W-1:0] MIX_C2    = 64'h94d049bb133111eb;
  localparam logic [ID_W-1:0] HASH_INIT = 64'h243f6a8885a308d3;
  localparam logic [ID_W-1:0] GOLDEN_X2 = GOLDEN * 64'd2;
  localparam logic [ID_W-1:0] GOLDEN_X3 = GOLDEN * 64'd3;
  localparam logic [ID_W-1:0] GOLDEN_X4 = GOLDEN * 64'd4;
  localparam logic [ID_W-1:0] GOLDEN_X5 = GOLDEN * 64'd5;

  localparam logic [LVL_W-1:0]  LEVEL_MAX   = 6'd63;
  localparam logic [MAXE_W-1:0] MAXE_RESET  = 12'd1024;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 13'd2;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_WRITE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    M_QUERY,
    M_JOIN,
    M_KID
  } mode_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  key;
    logic [ID_W-1:0]  ca;
    logic [ID_W-1:0]  cb;
    logic [ID_W-1:0]  cc;
    logic [ID_W-1:0]  cd;
    logic [LVL_W-1:0] height;
    logic [ID_W-1:0]  pop;
  } ent_t;

  // seed offset of child i inside the quad hash (its own offset plus the mixer's)
  function automatic logic [ID_W-1:0] child_bias(input logic [1:0] i);
    logic [ID_W-1:0] r;
    unique case (i)
      2'd0: r = GOLDEN_X2;
      2'd1: r = GOLDEN_X3;
      2'd2: r = GOLDEN_X4;
      default: r = GOLDEN_X5;
    endcase
    return r;
  endfunction

endpackage

/* rtl/quadtree_node_interning_table.sv */
// Quadtree node interning table: hash-consing over one synchronous entry memory.
// After reset the block sweeps the 4096-entry table once (in_tready low), leaving the
// empty leaf in slot 1 and the live leaf in slot 2; max_entries can be written at any
// time through the cfg port. A query walks each probed slot through a read state and
// a check state, then hands off the result. A join first computes the quad hash on
// one shared 32x32 multiplier, 14 multiplies in all. Every probed slot then passes the
// read and check states on the single read port (each remix after a clash adds 2
// multiplies), and an insert adds four child lookups of the same kind and a write state.
// Items are taken one at a time; a finished result waits in the output register while
// the next item is already accepted.
module quadtree_node_interning_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // child_a [63:0], child_b [127:64], child_c [191:128], child_d [255:192],
  // query_id [319:256]
  input  logic [319:0] in_tdata,
  // cmd [0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // node_id [63:0], node_level [69:64], node_pop [133:70], out_child_a [197:134],
  // out_child_b [261:198], out_child_c [325:262], out_child_d [389:326], zero pad
  output logic [391:0] out_tdata,
  // status [1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [qnit_pkg::MAXE_W-1:0] cfg_data
);
  import qnit_pkg::*;

  state_t st_r, st_nxt;
  mode_t  mode_r, mode_nxt;

  logic [1:0]        kid_r, kid_nxt;
  logic [2:0]        ci_r, ci_nxt;
  logic [1:0]        sk_r, sk_nxt;
  logic [1:0]        mph_r, mph_nxt;
  logic [ID_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   acc_r, acc_nxt;
  logic [ID_W-1:0]   h_r, h_nxt;
  logic [ID_W-1:0]   hsave_r, hsave_nxt;
  logic [ID_W-1:0]   a_r, b_r, c_r, d_r, qid_r;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [SLOT_W-1:0] pi_r, pi_nxt;
  logic [SLOT_W:0]   pn_r, pn_nxt;
  logic [SLOT_W:0]   rr_r, rr_nxt;
  logic [SLOT_W-1:0] w_r, w_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [ID_W-1:0]   pop_r, pop_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MAXE_W-1:0] max_r;
  logic [SLOT_W-1:0] clr_r;
  ent_t              res_r, res_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_v_r;
  ent_t              out_r;
  status_t           out_st_r;

  ent_t              mem [TABLE_SIZE];
  ent_t              rd_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  ent_t              mem_wd;

  logic            in_acc, emit_go;
  logic            hit, empty, last_slot, kids_match, room;
  logic [31:0]     mul_a, mul_b;
  logic [ID_W-1:0] mul_k, prod;
  logic [ID_W:0]   pop_sum;
  logic [ID_W-1:0] xt, hn;

  function automatic logic [ID_W-1:0] pick_kid(input logic [1:0] i, input logic [ID_W-1:0] a,
      input logic [ID_W-1:0] b, input logic [ID_W-1:0] c, input logic [ID_W-1:0] d);
    logic [ID_W-1:0] r;
    unique case (i)
      2'd0: r = a;
      2'd1: r = b;
      2'd2: r = c;
      default: r = d;
    endcase
    return r;
  endfunction

  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.cd, out_r.cc, out_r.cb, out_r.ca, out_r.pop,
                       out_r.height, out_r.key};
  assign out_tuser  = out_st_r;
  assign emit_go    = (st_r == S_EMIT) && (!out_v_r || out_tready);

  assign hit        = rd_q.valid && (rd_q.key == pid_r);
  assign empty      = !rd_q.valid;
  assign last_slot  = (pn_r == (SLOT_W+1)'(TABLE_SIZE - 1));
  assign kids_match = (rd_q.ca == a_r) && (rd_q.cb == b_r) && (rd_q.cc == c_r) &&
                      (rd_q.cd == d_r);
  assign room       = (cnt_r < {1'b0, max_r});
  assign pop_sum    = {1'b0, pop_r} + {1'b0, rd_q.pop};

  // one 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo
  always_comb begin
    unique case (sk_r)
      2'd0: mul_k = MIX_C1;
      2'd1: mul_k = MIX_C2;
      default: mul_k = GOLDEN;
    endcase
    mul_a = (mph_r == 2'd2) ? op_r[63:32] : op_r[31:0];
    mul_b = (mph_r == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    prod  = mul_a * mul_b;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLEAR: if (clr_r == '1) st_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) st_nxt = in_tuser[0] ? S_PROBE_RD : S_HASH;
      end
      S_HASH: begin
        if (mph_r == 2'd3 && sk_r == 2'd1 && ci_r == 3'd4) st_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: st_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (hit || empty || last_slot) begin
          unique case (mode_r)
            M_QUERY: st_nxt = S_EMIT;
            M_JOIN: begin
              if (hit && !kids_match && rr_r != (SLOT_W+1)'(TABLE_SIZE)) st_nxt = S_HASH;
              else if (empty && room) st_nxt = S_PROBE_RD;
              else st_nxt = S_EMIT;
            end
            default: st_nxt = (kid_r == 2'd3) ? S_WRITE : S_PROBE_RD;
          endcase
        end else begin
          st_nxt = S_PROBE_RD;
        end
      end
      S_WRITE: st_nxt = S_EMIT;
      S_EMIT: if (emit_go) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port controls
  always_comb begin
    mode_nxt   = mode_r;
    kid_nxt    = kid_r;
    ci_nxt     = ci_r;
    sk_nxt     = sk_r;
    mph_nxt    = mph_r;
    op_nxt     = op_r;
    acc_nxt    = acc_r;
    h_nxt      = h_r;
    hsave_nxt  = hsave_r;
    pid_nxt    = pid_r;
    pi_nxt     = pi_r;
    pn_nxt     = pn_r;
    rr_nxt     = rr_r;
    w_nxt      = w_r;
    lvl_nxt    = lvl_r;
    pop_nxt    = pop_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    res_st_nxt = res_st_r;
    mem_we     = 1'b0;
    mem_wa     = clr_r;
    mem_wd     = '0;
    xt         = '0;
    hn         = '0;
    unique case (st_r)
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_wa          = clr_r;
        mem_wd.valid    = (clr_r == SLOT_W'(1)) || (clr_r == SLOT_W'(2));
        mem_wd.key      = ID_W'(clr_r);
        mem_wd.pop      = ID_W'(clr_r == SLOT_W'(2));
      end
      S_IDLE: begin
        if (in_acc) begin
          mph_nxt = 2'd0;
          if (in_tuser[0]) begin
            mode_nxt = M_QUERY;
            pid_nxt  = in_tdata[319:256];
            pi_nxt   = in_tdata[256 +: SLOT_W];
            pn_nxt   = '0;
          end else begin
            h_nxt  = HASH_INIT;
            ci_nxt = 3'd0;
            sk_nxt = 2'd0;
            rr_nxt = '0;
            xt     = in_tdata[63:0] + child_bias(2'd0);
            op_nxt = xt ^ (xt >> 30);
          end
        end
      end
      S_HASH: begin
        mph_nxt = mph_r + 2'd1;
        if (mph_r == 2'd0) acc_nxt = prod;
        else if (mph_r != 2'd3) acc_nxt = acc_r + {prod[31:0], 32'b0};
        if (mph_r == 2'd3) begin
          unique case (sk_r)
            2'd0: begin
              op_nxt = acc_r ^ (acc_r >> 27);
              sk_nxt = 2'd1;
            end
            2'd1: begin
              xt = acc_r ^ (acc_r >> 31);
              if (ci_r == 3'd4) begin
                h_nxt    = xt;
                mode_nxt = M_JOIN;
                pid_nxt  = xt;
                pi_nxt   = xt[SLOT_W-1:0];
                pn_nxt   = '0;
              end else begin
                hn        = h_r ^ xt;
                hsave_nxt = hn;
                op_nxt    = hn;
                sk_nxt    = 2'd2;
              end
            end
            default: begin
              hn     = acc_r ^ (hsave_r >> 32);
              h_nxt  = hn;
              sk_nxt = 2'd0;
              if (ci_r == 3'd3) begin
                xt     = hn + GOLDEN;
                ci_nxt = 3'd4;
              end else begin
                xt     = pick_kid(ci_r[1:0] + 2'd1, a_r, b_r, c_r, d_r) +
                         child_bias(ci_r[1:0] + 2'd1);
                ci_nxt = ci_r + 3'd1;
              end
              op_nxt = xt ^ (xt >> 30);
            end
          endcase
        end
      end
      S_PROBE_CHK: begin
        if (hit || empty || last_slot) begin
          unique case (mode_r)
            M_QUERY: begin
              if (hit) begin
                res_nxt    = rd_q;
                res_st_nxt = ST_FOUND;
              end else begin
                res_nxt     = '0;
                res_nxt.key = qid_r;
                res_st_nxt  = ST_ABSENT;
              end
            end
            M_JOIN: begin
              res_nxt    = '0;
              res_st_nxt = ST_FULL;
              if (hit && kids_match) begin
                res_nxt    = rd_q;
                res_st_nxt = ST_FOUND;
              end else if (hit && rr_r != (SLOT_W+1)'(TABLE_SIZE)) begin
                // clash with other children: remix the id and walk again
                rr_nxt  = rr_r + 1'b1;
                xt      = h_r + GOLDEN;
                op_nxt  = xt ^ (xt >> 30);
                ci_nxt  = 3'd4;
                sk_nxt  = 2'd0;
                mph_nxt = 2'd0;
              end else if (empty && room) begin
                w_nxt    = pi_r;
                kid_nxt  = 2'd0;
                lvl_nxt  = '0;
                pop_nxt  = '0;
                mode_nxt = M_KID;
                pid_nxt  = a_r;
                pi_nxt   = a_r[SLOT_W-1:0];
                pn_nxt   = '0;
              end
            end
            default: begin
              if (hit) begin
                pop_nxt = pop_sum[ID_W] ? '1 : pop_sum[ID_W-1:0];
                if (kid_r == 2'd0) lvl_nxt = rd_q.height;
              end
              kid_nxt = kid_r + 2'd1;
              pid_nxt = pick_kid(kid_r + 2'd1, a_r, b_r, c_r, d_r);
              pi_nxt  = pid_nxt[SLOT_W-1:0];
              pn_nxt  = '0;
            end
          endcase
        end else begin
          pi_nxt = pi_r + 1'b1;
          pn_nxt = pn_r + 1'b1;
        end
      end
      S_WRITE: begin
        mem_we        = 1'b1;
        mem_wa        = w_r;
        mem_wd.valid  = 1'b1;
        mem_wd.key    = h_r;
        mem_wd.ca     = a_r;
        mem_wd.cb     = b_r;
        mem_wd.cc     = c_r;
        mem_wd.cd     = d_r;
        mem_wd.height = (lvl_r >= LEVEL_MAX) ? LEVEL_MAX : lvl_r + 1'b1;
        mem_wd.pop    = pop_r;
        res_nxt       = mem_wd;
        res_st_nxt    = ST_INSERTED;
        cnt_nxt       = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[pi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= COUNT_RESET;
      max_r   <= MAXE_RESET;
      out_v_r <= 1'b0;
      mph_r   <= 2'd0;
      mode_r  <= M_QUERY;
    end else begin
      st_r   <= st_nxt;
      mph_r  <= mph_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) max_r <= cfg_data;
      if (emit_go) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    kid_r    <= kid_nxt;
    ci_r     <= ci_nxt;
    sk_r     <= sk_nxt;
    op_r     <= op_nxt;
    acc_r    <= acc_nxt;
    h_r      <= h_nxt;
    hsave_r  <= hsave_nxt;
    pid_r    <= pid_nxt;
    pi_r     <= pi_nxt;
    pn_r     <= pn_nxt;
    rr_r     <= rr_nxt;
    w_r      <= w_nxt;
    lvl_r    <= lvl_nxt;
    pop_r    <= pop_nxt;
    res_r    <= res_nxt;
    res_st_r <= res_st_nxt;
    if (in_acc) begin
      a_r   <= in_tdata[63:0];
      b_r   <= in_tdata[127:64];
      c_r   <= in_tdata[191:128];
      d_r   <= in_tdata[255:192];
      qid_r <= in_tdata[319:256];
    end
    if (emit_go) begin
      out_r    <= res_r;
      out_st_r <= res_st_r;
    end
  end

  // multiplier phases only advance while hashing
  a_mph_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_HASH) |-> (mph_r == 2'd0))
    else $error("multiplier phase left running outside hashing");

  // the entry count moves only by one, and only on an insert
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(st_r) == S_WRITE && cnt_r == $past(cnt_r) + 1'b1))
    else $error("entry count changed outside an insert");

  // an insert is only reached when the count was below the limit
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WRITE) |-> (cnt_r < {1'b0, max_r}))
    else $error("insert past the entry limit");

  // every insert hands off an inserted status
  a_ins_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WRITE) |=> (res_st_r == ST_INSERTED))
    else $error("insert lost its status");

endmodule

/* tb/quadtree_node_interning_table_checker.sv */
// Checker for the node interning table: mirrors the table, predicts each result, compares.
`timescale 1ns / 1ps
module quadtree_node_interning_table_checker
  import qnit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [391:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [MAXE_W-1:0] cfg_data,
  output int           errors,
  output int           pending
);

  localparam logic [1:0] PR_HIT   = 2'd0;
  localparam logic [1:0] PR_EMPTY = 2'd1;
  localparam logic [1:0] PR_NONE  = 2'd2;
  localparam logic       CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lvl;
    logic [ID_W-1:0]  pop;
    status_t          st;
    logic [ID_W-1:0]  ca;
    logic [ID_W-1:0]  cb;
    logic [ID_W-1:0]  cc;
    logic [ID_W-1:0]  cd;
  } node_result_t;

  logic [ID_W-1:0]  tbl_key [TABLE_SIZE];
  logic             tbl_used[TABLE_SIZE];
  logic [ID_W-1:0]  tbl_ca  [TABLE_SIZE];
  logic [ID_W-1:0]  tbl_cb  [TABLE_SIZE];
  logic [ID_W-1:0]  tbl_cc  [TABLE_SIZE];
  logic [ID_W-1:0]  tbl_cd  [TABLE_SIZE];
  logic [LVL_W-1:0] tbl_lvl [TABLE_SIZE];
  logic [ID_W-1:0]  tbl_pop [TABLE_SIZE];
  logic [CNT_W-1:0] live_count;
  logic [MAXE_W-1:0] entry_limit;
  node_result_t     expected_nodes[$];

  function automatic logic [ID_W-1:0] mix64(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] x;
    x = v + GOLDEN;
    x = (x ^ (x >> 30)) * MIX_C1;
    x = (x ^ (x >> 27)) * MIX_C2;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [ID_W-1:0] node_hash(input logic [ID_W-1:0] a, b, c, d);
    logic [ID_W-1:0] h;
    h = HASH_INIT;
    h ^= mix64(a + GOLDEN);
    h = (h * GOLDEN) ^ (h >> 32);
    h ^= mix64(b + GOLDEN * 64'd2);
    h = (h * GOLDEN) ^ (h >> 32);
    h ^= mix64(c + GOLDEN * 64'd3);
    h = (h * GOLDEN) ^ (h >> 32);
    h ^= mix64(d + GOLDEN * 64'd4);
    h = (h * GOLDEN) ^ (h >> 32);
    return mix64(h);
  endfunction

  // linear probe from the low id bits; gives up after one full lap
  function automatic logic [1:0] probe(input logic [ID_W-1:0] id, output int slot);
    int i;
    i = int'(id[SLOT_W-1:0]);
    slot = 0;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (!tbl_used[i]) begin
        slot = i;
        return PR_EMPTY;
      end
      if (tbl_key[i] == id) begin
        slot = i;
        return PR_HIT;
      end
      i = (i + 1) % TABLE_SIZE;
    end
    return PR_NONE;
  endfunction

  function automatic node_result_t slot_result(input int s, input status_t st);
    node_result_t r;
    r.id = tbl_key[s];
    r.lvl = tbl_lvl[s];
    r.pop = tbl_pop[s];
    r.st = st;
    r.ca = tbl_ca[s];
    r.cb = tbl_cb[s];
    r.cc = tbl_cc[s];
    r.cd = tbl_cd[s];
    return r;
  endfunction

  function automatic node_result_t intern_join(input logic [ID_W-1:0] a, b, c, d);
    node_result_t r;
    logic [ID_W-1:0] h, pop, sum;
    logic [ID_W-1:0] kids[4];
    logic [1:0] k;
    int w, s, lvl;
    r = '0;
    r.st = ST_FULL;
    kids = '{a, b, c, d};
    h = node_hash(a, b, c, d);
    for (int rem = 0; rem <= TABLE_SIZE; rem++) begin
      k = probe(h, w);
      if (k == PR_HIT) begin
        if (tbl_ca[w] == a && tbl_cb[w] == b && tbl_cc[w] == c && tbl_cd[w] == d)
          return slot_result(w, ST_FOUND);
        h = mix64(h);
        continue;
      end
      if (k == PR_EMPTY && live_count < CNT_W'(entry_limit)) begin
        pop = '0;
        lvl = 0;
        for (int i = 0; i < 4; i++) begin
          if (probe(kids[i], s) == PR_HIT) begin
            sum = pop + tbl_pop[s];
            pop = (sum < pop) ? '1 : sum;
            if (i == 0) lvl = tbl_lvl[s];
          end
        end
        lvl = (lvl >= 63) ? 63 : lvl + 1;
        tbl_key[w] = h;
        tbl_used[w] = 1'b1;
        tbl_ca[w] = a;
        tbl_cb[w] = b;
        tbl_cc[w] = c;
        tbl_cd[w] = d;
        tbl_lvl[w] = LVL_W'(lvl);
        tbl_pop[w] = pop;
        live_count = live_count + 1'b1;
        return slot_result(w, ST_INSERTED);
      end
      break;
    end
    return r;
  endfunction

  function automatic node_result_t lookup_node(input logic [ID_W-1:0] qid);
    node_result_t r;
    int w;
    if (probe(qid, w) == PR_HIT) return slot_result(w, ST_FOUND);
    r = '0;
    r.id = qid;
    r.st = ST_ABSENT;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ID_W-1:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_key[i] = '0;
      tbl_used[i] = 1'b0;
      tbl_ca[i] = '0;
      tbl_cb[i] = '0;
      tbl_cc[i] = '0;
      tbl_cd[i] = '0;
      tbl_lvl[i] = '0;
      tbl_pop[i] = '0;
    end
    tbl_key[1] = 64'd1;
    tbl_used[1] = 1'b1;
    tbl_key[2] = 64'd2;
    tbl_used[2] = 1'b1;
    tbl_pop[2] = 64'd1;
    live_count = COUNT_RESET;
    entry_limit = MAXE_RESET;
  end

  assign pending = expected_nodes.size();

  always @(posedge clk) begin
    node_result_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) entry_limit = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_QUERY)
          expected_nodes.push_back(lookup_node(in_tdata[319:256]));
        else
          expected_nodes.push_back(intern_join(in_tdata[63:0], in_tdata[127:64],
                                               in_tdata[191:128], in_tdata[255:192]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h / %h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          e = expected_nodes.pop_front();
          check_field("node_id", e.id, out_tdata[63:0]);
          check_field("node_level", ID_W'(e.lvl), ID_W'(out_tdata[69:64]));
          check_field("node_pop", e.pop, out_tdata[133:70]);
          check_field("status", ID_W'(e.st), ID_W'(out_tuser));
          check_field("child_a", e.ca, out_tdata[197:134]);
          check_field("child_b", e.cb, out_tdata[261:198]);
          check_field("child_c", e.cc, out_tdata[325:262]);
          check_field("child_d", e.cd, out_tdata[389:326]);
        end
      end
    end
  end

endmodule

/* tb/quadtree_node_interning_table_test.sv */
// Testbench top for the node interning table: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module quadtree_node_interning_table_test;
  import qnit_pkg::*;

  localparam logic CMD_JOIN  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;
  localparam logic [ID_W-1:0] ALL_ONES = '1;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [391:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [MAXE_W-1:0] cfg_data;
  int           errors;
  int           pending;
  int           cycle_count;
  int           results_seen;
  logic [ID_W-1:0] last_id;
  logic [ID_W-1:0] known_ids[$];
  logic [ID_W-1:0] recent_joins[$];
  logic         calm;

  quadtree_node_interning_table i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  quadtree_node_interning_table_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data, .errors, .pending
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, harvest ids of live nodes for later joins
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        last_id <= out_tdata[63:0];
        if (out_tuser == ST_FOUND || out_tuser == ST_INSERTED)
          known_ids.push_back(out_tdata[63:0]);
      end
      out_tready <= calm || ($urandom_range(99) >= 13);
    end
  end

  function automatic logic [ID_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] pick_child();
    if ($urandom_range(9) == 0) return rand64();
    return known_ids[$urandom_range(known_ids.size() - 1)];
  endfunction

  task automatic send(input logic cmd, input logic [ID_W-1:0] a, b, c, d, qid);
    if (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {qid, d, c, b, a};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_JOIN) begin
      recent_joins.push_back(a);
      recent_joins.push_back(b);
      recent_joins.push_back(c);
      recent_joins.push_back(d);
      if (recent_joins.size() > 400) repeat (4) void'(recent_joins.pop_front());
    end
  endtask

  // let earlier results drain first so the result seen here belongs to this join
  task automatic join_wait(input logic [ID_W-1:0] a, b, c, d);
    int seen;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    seen = results_seen;
    send(CMD_JOIN, a, b, c, d, rand64());
    in_tvalid <= 1'b0;
    while (results_seen == seen) @(posedge clk);
  endtask

  task automatic drain_and_set(input logic [MAXE_W-1:0] limit);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int sel, j;
    for (int n = 0; n < count; n++) begin
      calm = (n >= 300 && n < 550);
      sel = $urandom_range(99);
      if (sel < 55) begin
        send(CMD_JOIN, pick_child(), pick_child(), pick_child(), pick_child(), rand64());
      end else if (sel < 70 && recent_joins.size() >= 4) begin
        // resend an earlier join: should hit the existing node
        j = 4 * $urandom_range(recent_joins.size() / 4 - 1);
        send(CMD_JOIN, recent_joins[j], recent_joins[j+1], recent_joins[j+2],
             recent_joins[j+3], rand64());
      end else if (sel < 90) begin
        send(CMD_QUERY, rand64(), rand64(), rand64(), rand64(), pick_child());
      end else begin
        send(CMD_QUERY, rand64(), rand64(), rand64(), rand64(), rand64());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [ID_W-1:0] node;
    cycle_count = 0;
    results_seen = 0;
    last_id = '0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_JOIN;
    cfg_valid = 1'b0;
    cfg_data = '0;
    known_ids.push_back(64'd1);
    known_ids.push_back(64'd2);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // tightest limit: one insert fits, then the table reports full
    drain_and_set(12'd3);
    send(CMD_QUERY, '0, '0, '0, '0, 64'd0);
    send(CMD_QUERY, '0, '0, '0, '0, 64'd1);
    send(CMD_QUERY, '0, '0, '0, '0, 64'd2);
    send(CMD_QUERY, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send(CMD_JOIN, 64'd2, 64'd1, 64'd2, 64'd1, ALL_ONES);
    send(CMD_JOIN, 64'd2, 64'd1, 64'd2, 64'd1, '0);
    send(CMD_JOIN, ALL_ONES, '0, ALL_ONES, '0, '0);
    send(CMD_JOIN, 64'd2, 64'd1, 64'd2, 64'd1, '0);

    // widest limit: a chain of self joins drives level and population to saturation
    drain_and_set(12'd4095);
    send(CMD_JOIN, '0, '0, '0, '0, '0);
    send(CMD_JOIN, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0);
    node = 64'd2;
    for (int lv = 0; lv < 66; lv++) begin
      join_wait(node, node, node, node);
      node = last_id;
    end
    send(CMD_QUERY, '0, '0, '0, '0, node);
    send(CMD_JOIN, node, 64'd1, node, 64'd2, '0);
    random_items(1650);

    // limit far below the live count: every insert refused, hits still served
    drain_and_set(12'd5);
    random_items(60);

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
